// ----- src/sorted_set_engine_defines.svh -----
// Assertion macros used by the checker of the sorted set engine.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef SORTED_SET_ENGINE_DEFINES_SVH
`define SORTED_SET_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define SSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sse_pkg.sv -----
`default_nettype none

package sse_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned TOTAL_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_GET      = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_KEY,
    ST_REM_RD,
    ST_REM_WR,
    ST_REM_END,
    ST_GET_RD,
    ST_GET_DATA,
    ST_DONE
  } state_e;

  // Store access issued by the sequencer.
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } store_req_t;

  // Outcome of the shared comparator.
  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- src/sse_if.sv -----
`default_nettype none

interface sse_req_if import sse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key_value;
  logic [IDX_W-1:0]        position_index;

  modport source (output valid, cmd, key_value, position_index, input ready);
  modport sink   (input valid, cmd, key_value, position_index, output ready);
endinterface

interface sse_rsp_if import sse_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [KEY_W-1:0] read_value;
  logic [TOTAL_W-1:0]      entry_total;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, hit, read_value, entry_total, status, input ready);
  modport sink   (input valid, hit, read_value, entry_total, status, output ready);
endinterface

`default_nettype wire

// ----- src/sorted_set_engine.sv -----
// Ordered set of up to 16 distinct signed 32-bit keys, kept in ascending order in a
// store with one write port and one registered read port. Each request transaction
// (insert, remove, contains, get by index) yields exactly one response transaction
// carrying hit, the value read (get only), the entry count after the operation and
// a status (ok, full, index out of range). The block takes one request at a time.
// A get with a valid index reads the store before it responds; one with a bad index
// skips the store. Insert, remove and contains run a linear lower-bound search that
// reads and compares one entry at a time; an insert or remove that changes the set
// then shifts the entries behind the position with one read and one write each, and
// updates the entry count (an insert also writes the key). The request side is ready
// again in the cycle the response turns valid. The search and the shifts share the
// store, whose read is registered, and the search uses a single comparator. A
// finished response sits in an output register, so the next request is accepted
// while it waits to be taken.
`default_nettype none

module sorted_set_engine import sse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sse_req_if.sink   req_i,
  sse_rsp_if.source rsp_o
);

  store_req_t            store_req;
  logic [VALUE_BITS-1:0] store_rdata;
  cmp_res_t              cmp_res;
  logic [VALUE_BITS-1:0] cmp_key;

  sse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .store_o (store_req),
    .key_o   (cmp_key),
    .rdata_i (store_rdata),
    .cmp_i   (cmp_res)
  );

  sse_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  sse_cmp u_cmp (
    .entry_i (store_rdata),
    .key_i   (cmp_key),
    .res_o   (cmp_res)
  );

endmodule

`default_nettype wire

// ----- src/sse_store.sv -----
`default_nettype none

module sse_store import sse_pkg::*; (
  input  wire logic                  clk_i,
  input  wire store_req_t            req_i,
  output logic [VALUE_BITS-1:0]      rdata_o
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/sse_cmp.sv -----
`default_nettype none

module sse_cmp import sse_pkg::*; (
  input  wire logic [VALUE_BITS-1:0] entry_i,
  input  wire logic [VALUE_BITS-1:0] key_i,
  output cmp_res_t                   res_o
);

  // Two's complement order on the stored patterns.
  always_comb begin
    res_o.less  = $signed(entry_i) < $signed(key_i);
    res_o.equal = entry_i == key_i;
  end

endmodule

`default_nettype wire

// ----- src/sse_ctrl.sv -----
`default_nettype none

module sse_ctrl import sse_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sse_req_if.sink                    req_i,
  sse_rsp_if.source                  rsp_o,
  output store_req_t                 store_o,
  output logic [VALUE_BITS-1:0]      key_o,
  input  wire logic [VALUE_BITS-1:0] rdata_i,
  input  wire cmp_res_t              cmp_i
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;

  cmd_e                  cmd_q, cmd_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  logic [CNT_W-1:0]      j_q, j_d;
  logic                  hit_q, hit_d;
  logic [VALUE_BITS-1:0] rd_q, rd_d;
  status_e               status_q, status_d;

  logic                  out_hit_q, out_hit_d;
  logic [KEY_W-1:0]      out_rd_q, out_rd_d;
  logic [TOTAL_W-1:0]    out_total_q, out_total_d;
  status_e               out_status_q, out_status_d;

  logic                  idx_ok;
  logic                  slot_free;
  logic [CNT_W-1:0]      pos_inc, j_inc, j_inc2, j_dec;

  assign idx_ok    = 32'(req_i.position_index) < 32'(count_q);
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign pos_inc   = pos_q + CNT_W'(1);
  assign j_inc     = j_q + CNT_W'(1);
  assign j_inc2    = j_q + CNT_W'(2);
  assign j_dec     = j_q - CNT_W'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (cmd_e'(req_i.cmd) == CMD_GET) begin
            state_d = idx_ok ? ST_GET_RD : ST_DONE;
          end else begin
            state_d = (count_q == '0) ? ST_DECIDE : ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        state_d = (cmp_i.less && pos_inc != count_q) ? ST_SRCH_RD : ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (cmd_q == CMD_INSERT && !hit_q) begin
          priority if (count_q == CNT_W'(DEPTH)) state_d = ST_DONE;
          else if (count_q != pos_q)             state_d = ST_INS_RD;
          else                                   state_d = ST_INS_KEY;
        end else if (cmd_q == CMD_REMOVE && hit_q) begin
          state_d = (pos_inc < count_q) ? ST_REM_RD : ST_REM_END;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_INS_RD:   state_d = ST_INS_WR;
      ST_INS_WR:   state_d = (j_dec != pos_q) ? ST_INS_RD : ST_INS_KEY;
      ST_INS_KEY:  state_d = ST_DONE;
      ST_REM_RD:   state_d = ST_REM_WR;
      ST_REM_WR:   state_d = (j_inc2 < count_q) ? ST_REM_RD : ST_REM_END;
      ST_REM_END:  state_d = ST_DONE;
      ST_GET_RD:   state_d = ST_GET_DATA;
      ST_GET_DATA: state_d = ST_DONE;
      ST_DONE:     state_d = slot_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and store control.
  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    cmd_d        = cmd_q;
    key_d        = key_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    j_d          = j_q;
    hit_d        = hit_q;
    rd_d         = rd_q;
    status_d     = status_q;
    out_hit_d    = out_hit_q;
    out_rd_d     = out_rd_q;
    out_total_d  = out_total_q;
    out_status_d = out_status_q;
    store_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d    = cmd_e'(req_i.cmd);
          key_d    = VALUE_BITS'($signed(req_i.key_value));
          idx_d    = req_i.position_index;
          pos_d    = '0;
          hit_d    = 1'b0;
          rd_d     = '0;
          status_d = STATUS_OK;
          if (cmd_e'(req_i.cmd) == CMD_GET && !idx_ok) begin
            status_d = STATUS_RANGE;
          end
        end
      end
      ST_SRCH_RD: store_o.raddr = pos_q[ADDR_W-1:0];
      ST_SRCH_CMP: begin
        // Advance past smaller entries; stop at the first one not below the key, or after the last entry.
        if (cmp_i.less) begin
          pos_d = pos_inc;
        end else begin
          hit_d = cmp_i.equal;
        end
      end
      ST_DECIDE: begin
        priority if (cmd_q == CMD_INSERT && !hit_q) begin
          if (count_q == CNT_W'(DEPTH)) begin
            status_d = STATUS_FULL;
          end
          j_d = count_q;
        end else if (cmd_q == CMD_REMOVE && hit_q) begin
          j_d = pos_q;
        end else begin
          j_d = j_q;
        end
      end
      ST_INS_RD: store_o.raddr = j_dec[ADDR_W-1:0];
      ST_INS_WR: begin
        store_o.we    = 1'b1;
        store_o.waddr = j_q[ADDR_W-1:0];
        store_o.wdata = rdata_i;
        j_d           = j_dec;
      end
      ST_INS_KEY: begin
        store_o.we    = 1'b1;
        store_o.waddr = pos_q[ADDR_W-1:0];
        store_o.wdata = key_q;
        count_d       = count_q + CNT_W'(1);
      end
      ST_REM_RD: store_o.raddr = j_inc[ADDR_W-1:0];
      ST_REM_WR: begin
        store_o.we    = 1'b1;
        store_o.waddr = j_q[ADDR_W-1:0];
        store_o.wdata = rdata_i;
        j_d           = j_inc;
      end
      ST_REM_END: count_d = count_q - CNT_W'(1);
      ST_GET_RD:  store_o.raddr = idx_q[ADDR_W-1:0];
      ST_GET_DATA: begin
        hit_d = 1'b1;
        rd_d  = rdata_i;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_hit_d    = hit_q;
          out_rd_d     = KEY_W'($signed(rd_q));
          out_total_d  = TOTAL_W'(count_q);
          out_status_d = status_q;
        end
      end
      default: begin
        store_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    j_q          <= j_d;
    hit_q        <= hit_d;
    rd_q         <= rd_d;
    status_q     <= status_d;
    out_hit_q    <= out_hit_d;
    out_rd_q     <= out_rd_d;
    out_total_q  <= out_total_d;
    out_status_q <= out_status_d;
  end

  assign key_o             = key_q;
  assign req_i.ready       = state_q == ST_IDLE;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_rd_q;
  assign rsp_o.entry_total = out_total_q;
  assign rsp_o.status      = out_status_q;

endmodule

`default_nettype wire

// ----- src/sse_chk.sv -----
`default_nettype none
`include "sorted_set_engine_defines.svh"

module sse_chk import sse_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic                rsp_hit_i,
  input wire logic [KEY_W-1:0]    rsp_read_value_i,
  input wire logic [TOTAL_W-1:0]  rsp_entry_total_i,
  input wire logic [STATUS_W-1:0] rsp_status_i
);

  `SSE_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_read_value_i) && $stable(rsp_entry_total_i) && $stable(rsp_status_i), "stalled response changed")
  `SSE_ASSERT_IMP(a_total_max, rsp_valid_i, rsp_entry_total_i <= TOTAL_W'(DEPTH), "entry count above depth")
  `SSE_ASSERT_IMP(a_full_cnt, rsp_valid_i && rsp_status_i == STATUS_FULL, rsp_entry_total_i == TOTAL_W'(DEPTH) && !rsp_hit_i, "full status with free room or hit")
  `SSE_ASSERT_IMP(a_err_clean, rsp_valid_i && rsp_status_i != STATUS_OK, !rsp_hit_i && rsp_read_value_i == '0, "error response carries hit or data")

endmodule

bind sorted_set_engine sse_chk u_sse_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_entry_total_i (rsp_o.entry_total),
  .rsp_status_i      (rsp_o.status)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sse_pkg::*;

  localparam int unsigned N_RANDOM   = 1450;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned TAIL_WAIT  = 100;
  localparam int unsigned POOL_SIZE  = 24;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MIN = 32'h8000_0000;
  localparam key_t KEY_MAX = 32'h7fff_ffff;

  typedef struct {
    cmd_e             cmd;
    key_t             key;
    logic [IDX_W-1:0] idx;
  } set_req_t;

  typedef struct {
    logic               hit;
    key_t               rd;
    logic [TOTAL_W-1:0] total;
    status_e            status;
  } set_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sse_req_if req_if ();
  sse_rsp_if rsp_if ();

  sorted_set_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Driven copies of the block inputs, known from time zero.
  logic             drv_valid  = 1'b0;
  logic [CMD_W-1:0] drv_cmd    = '0;
  key_t             drv_key    = '0;
  logic [IDX_W-1:0] drv_idx    = '0;
  logic             sink_ready = 1'b0;

  assign req_if.valid          = drv_valid;
  assign req_if.cmd            = drv_cmd;
  assign req_if.key_value      = drv_key;
  assign req_if.position_index = drv_idx;
  assign rsp_if.ready          = sink_ready;

  set_req_t request_q[$];
  set_rsp_t outcome_q[$];
  key_t     set_keys[$];

  set_req_t    drv_item;
  set_rsp_t    want;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          drv_burst  = 1'b0;
  bit          snk_burst  = 1'b0;
  bit          drv_busy;
  int unsigned n_fail     = 0;
  int unsigned n_checked  = 0;
  int unsigned op_cnt[4]  = '{0, 0, 0, 0};
  int unsigned n_full     = 0;
  int unsigned n_range    = 0;
  int unsigned n_hit      = 0;
  int unsigned peak_total = 0;
  int unsigned cycle_cnt  = 0;

  // Apply one request to the shadow set and return the response it yields.
  function automatic set_rsp_t apply_set_op(set_req_t it);
    set_rsp_t r;
    int       pos;
    bit       found;
    r.hit    = 1'b0;
    r.rd     = '0;
    r.status = STATUS_OK;
    op_cnt[it.cmd]++;
    if (it.cmd == CMD_GET) begin
      if (it.idx < set_keys.size()) begin
        r.hit = 1'b1;
        r.rd  = set_keys[it.idx];
      end else begin
        r.status = STATUS_RANGE;
        n_range++;
      end
    end else begin
      // lower bound: first entry not less than the key
      pos = 0;
      while (pos < set_keys.size() && set_keys[pos] < it.key) pos++;
      found = (pos < set_keys.size()) && (set_keys[pos] == it.key);
      r.hit = found;
      if (it.cmd == CMD_INSERT && !found) begin
        if (set_keys.size() >= DEPTH) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          set_keys.insert(pos, it.key);
        end
      end else if (it.cmd == CMD_REMOVE && found) begin
        set_keys.delete(pos);
      end
    end
    if (r.hit) n_hit++;
    if (set_keys.size() > peak_total) peak_total = set_keys.size();
    r.total = TOTAL_W'(set_keys.size());
    return r;
  endfunction

  task automatic push_req(input cmd_e c, input key_t k, input logic [IDX_W-1:0] i);
    set_req_t it;
    it.cmd = c;
    it.key = k;
    it.idx = i;
    request_q.push_back(it);
  endtask

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               outcome_q.size());
      $display("[sorted_set_engine] ERROR");
      $finish;
    end
  end

  // Request driver: present queued transactions, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      gap_left = 0;
    end else begin
      drv_busy = drv_valid;
      if (drv_valid && req_if.ready) begin
        outcome_q.push_back(apply_set_op(drv_item));
        drv_busy = 1'b0;
        gap_left = drv_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) drv_burst = !drv_burst;
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          drv_item = request_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      drv_valid <= drv_busy;
      drv_cmd   <= drv_item.cmd;
      drv_key   <= drv_item.key;
      drv_idx   <= drv_item.idx;
    end
  end

  // Response monitor: take results with random stalls and check each field.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && sink_ready) begin
        if (outcome_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          n_fail++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp_if.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
            n_fail++;
          end
          if (rsp_if.read_value !== want.rd) begin
            $error("read_value: expected %0d, got %0d", want.rd, rsp_if.read_value);
            n_fail++;
          end
          if (rsp_if.entry_total !== want.total) begin
            $error("entry_total: expected %0d, got %0d", want.total, rsp_if.entry_total);
            n_fail++;
          end
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            n_fail++;
          end
          n_checked++;
        end
        stall_left = snk_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) snk_burst = !snk_burst;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      sink_ready <= (stall_left == 0);
    end
  end

  initial begin
    key_t        key_pool[POOL_SIZE];
    key_t        k;
    cmd_e        c;
    int unsigned bias;
    int unsigned roll;
    logic [IDX_W-1:0] ix;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, extremes, duplicates, misses, bad indexes.
    push_req(CMD_GET,      '0,      16'd0);
    push_req(CMD_GET,      '0,      16'hffff);
    push_req(CMD_CONTAINS, KEY_MIN, 16'd0);
    push_req(CMD_REMOVE,   KEY_MAX, 16'd0);
    push_req(CMD_INSERT,   KEY_MAX, 16'hffff);
    push_req(CMD_INSERT,   KEY_MIN, 16'd0);
    push_req(CMD_INSERT,   '0,      16'd0);
    push_req(CMD_INSERT,   -1,      16'd0);
    push_req(CMD_INSERT,   '0,      16'd0);
    push_req(CMD_CONTAINS, KEY_MAX, 16'd0);
    push_req(CMD_CONTAINS, 1,       16'd0);
    push_req(CMD_GET,      '0,      16'd0);
    push_req(CMD_GET,      '0,      16'd3);
    push_req(CMD_GET,      '0,      16'd4);
    push_req(CMD_REMOVE,   KEY_MIN, 16'd0);
    push_req(CMD_REMOVE,   KEY_MIN, 16'd0);
    push_req(CMD_REMOVE,   KEY_MAX, 16'd0);
    push_req(CMD_CONTAINS, KEY_MIN, 16'd0);
    push_req(CMD_GET,      -1,      16'd1);
    push_req(CMD_GET,      KEY_MAX, 16'd2);

    // Hold off until the directed part has fully drained.
    while (request_q.size() > 0 || drv_valid || outcome_q.size() > 0) @(posedge clk_i);

    // Random: phases biased toward filling, draining or a mix over a small key pool,
    // so the store reaches full and empty often.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) begin
        bias = $urandom_range(0, 2);
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (int p = 4; p < POOL_SIZE; p++)
          key_pool[p] = (p % 2) ? key_t'($urandom) : key_t'($urandom_range(0, 200)) - 100;
      end
      if (n == N_RANDOM / 2) begin
        while (request_q.size() > 0 || drv_valid || outcome_q.size() > 0) @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      case (bias)
        0: begin
          if (roll < 65) c = CMD_INSERT;
          else if (roll < 75) c = CMD_REMOVE;
          else if (roll < 88) c = CMD_CONTAINS;
          else c = CMD_GET;
        end
        1: begin
          if (roll < 15) c = CMD_INSERT;
          else if (roll < 65) c = CMD_REMOVE;
          else if (roll < 82) c = CMD_CONTAINS;
          else c = CMD_GET;
        end
        default: begin
          if (roll < 30) c = CMD_INSERT;
          else if (roll < 55) c = CMD_REMOVE;
          else if (roll < 80) c = CMD_CONTAINS;
          else c = CMD_GET;
        end
      endcase
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : key_t'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 70) ix = IDX_W'($urandom_range(0, DEPTH));
      else if (roll < 85) ix = IDX_W'($urandom_range(0, DEPTH + 4));
      else ix = IDX_W'($urandom);
      push_req(c, k, ix);
    end

    while (request_q.size() > 0 || drv_valid || outcome_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("checked %0d responses: %0d insert, %0d remove, %0d contains, %0d get",
             n_checked, op_cnt[CMD_INSERT], op_cnt[CMD_REMOVE], op_cnt[CMD_CONTAINS],
             op_cnt[CMD_GET]);
    $display("hits %0d, full drops %0d, bad indexes %0d, peak entries %0d",
             n_hit, n_full, n_range, peak_total);
    if (n_fail == 0) begin
      $display("[sorted_set_engine] OK");
    end else begin
      $display("[sorted_set_engine] ERROR");
    end
    $finish;
  end

endmodule
